// File: sv/cubic_bezier_point_generator_assert.svh
// Assertion macros for the cubic Bezier point generator checker.
`ifndef CUBIC_BEZIER_POINT_GENERATOR_ASSERT_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBPG_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("cbpg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBPG_ASSERT_NXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("cbpg assertion failed");

`endif

// File: sv/cbpg_pkg.sv
// Shared constants for the cubic Bezier point generator.
`default_nettype none
package cbpg_pkg;
	localparam int IDX_W = 12;
	localparam int CNT_W = 13;
	localparam int MAX_SAMPLES = 4096;
	// Largest count the sample_count field can carry after clamping
	localparam logic [CNT_W-1:0] CNT_MAX =
		CNT_W'((MAX_SAMPLES > (2**CNT_W - 1)) ? (2**CNT_W - 1) : MAX_SAMPLES);
	localparam int QDEPTH = 4;
	localparam int QAW = 2;
endpackage
`default_nettype wire

// File: sv/cbpg_front.sv
// Front part: accepts requests, forms coefficients and the curve parameter t.
`default_nettype none
module cbpg_front
	import cbpg_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int T_FRACTION_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         sample_valid,
	output logic                              sample_stall,
	input  wire logic signed [COORD_BITS-1:0] p0_x,
	input  wire logic signed [COORD_BITS-1:0] p0_y,
	input  wire logic signed [COORD_BITS-1:0] p1_x,
	input  wire logic signed [COORD_BITS-1:0] p1_y,
	input  wire logic signed [COORD_BITS-1:0] p2_x,
	input  wire logic signed [COORD_BITS-1:0] p2_y,
	input  wire logic signed [COORD_BITS-1:0] p3_x,
	input  wire logic signed [COORD_BITS-1:0] p3_y,
	input  wire logic [IDX_W-1:0]             sample_index,
	input  wire logic [CNT_W-1:0]             sample_count,
	input  wire logic                         q_full,
	output logic                              q_push,
	output logic [T_FRACTION_BITS:0]          t_val,
	output logic signed [COORD_BITS+3:0]      ax,
	output logic signed [COORD_BITS+3:0]      bx,
	output logic signed [COORD_BITS+3:0]      cx,
	output logic signed [COORD_BITS+3:0]      ay,
	output logic signed [COORD_BITS+3:0]      by,
	output logic signed [COORD_BITS+3:0]      cy,
	output logic signed [COORD_BITS-1:0]      x0,
	output logic signed [COORD_BITS-1:0]      y0,
	output logic                              clip
);
	localparam int CW = COORD_BITS;
	localparam int F = T_FRACTION_BITS;
	localparam int KW = CW + 4;
	localparam int DW = CNT_W;

	typedef struct packed {
		logic signed [KW-1:0] ax;
		logic signed [KW-1:0] bx;
		logic signed [KW-1:0] cx;
		logic signed [KW-1:0] ay;
		logic signed [KW-1:0] by;
		logic signed [KW-1:0] cy;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic                 one;
		logic                 zero;
		logic                 clip;
	} item_t;

	logic                 en;
	logic [CNT_W-1:0]     cnt_sat;
	logic [CNT_W-1:0]     den;
	logic                 over_cnt;
	logic                 short_cnt;
	logic                 at_end;
	logic                 past_end;
	logic signed [KW-1:0] ex0, ex1, ex2, ex3, ey0, ey1, ey2, ey3;
	logic signed [KW-1:0] dx01, dx12, sx02, dy01, dy12, sy02;
	item_t                item_d;

	logic [F:0]           vld_s;
	item_t                item_s [0:F];
	logic [DW-1:0]        rem_s [0:F];
	logic [DW-1:0]        den_s [0:F];
	logic [F-1:0]         quo_s [0:F];
	logic [DW:0]          r2 [1:F];
	logic [DW:0]          diff [1:F];
	logic [DW-1:0]        rem_n [1:F];
	logic [F:1]           qb_n;

	// Stall the whole front while the queue has no room
	assign en = !q_full;
	assign sample_stall = q_full;

	// Clamp the count and classify the request
	always_comb begin
		over_cnt = sample_count > CNT_MAX;
		cnt_sat = over_cnt ? CNT_MAX : sample_count;
		short_cnt = cnt_sat < CNT_W'(2);
		den = cnt_sat - CNT_W'(1);
		at_end = !short_cnt && (CNT_W'(sample_index) >= den);
		past_end = !short_cnt && (CNT_W'(sample_index) > den);
	end

	// Form power-basis coefficients: c = 3(P1-P0), b = 3(P0-2P1+P2), a = P3-P0+3(P1-P2)
	always_comb begin
		ex0 = KW'(p0_x);
		ex1 = KW'(p1_x);
		ex2 = KW'(p2_x);
		ex3 = KW'(p3_x);
		ey0 = KW'(p0_y);
		ey1 = KW'(p1_y);
		ey2 = KW'(p2_y);
		ey3 = KW'(p3_y);
		dx01 = ex1 - ex0;
		dx12 = ex1 - ex2;
		sx02 = ex0 + ex2 - (ex1 <<< 1);
		dy01 = ey1 - ey0;
		dy12 = ey1 - ey2;
		sy02 = ey0 + ey2 - (ey1 <<< 1);
		item_d.cx = dx01 + (dx01 <<< 1);
		item_d.bx = sx02 + (sx02 <<< 1);
		item_d.ax = (ex3 - ex0) + (dx12 + (dx12 <<< 1));
		item_d.cy = dy01 + (dy01 <<< 1);
		item_d.by = sy02 + (sy02 <<< 1);
		item_d.ay = (ey3 - ey0) + (dy12 + (dy12 <<< 1));
		item_d.x0 = p0_x;
		item_d.y0 = p0_y;
		item_d.one = at_end;
		item_d.zero = short_cnt;
		item_d.clip = over_cnt || past_end;
	end

	// One restoring-division step per stage: index * 2^F / (count - 1)
	always_comb begin
		for (int k = 1; k <= F; k++) begin
			r2[k] = {rem_s[k-1], 1'b0};
			diff[k] = r2[k] - {1'b0, den_s[k-1]};
			qb_n[k] = r2[k] >= {1'b0, den_s[k-1]};
			rem_n[k] = qb_n[k] ? diff[k][DW-1:0] : r2[k][DW-1:0];
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[F-1:0], sample_valid};
		end
	end

	// Advance the payload and the divider
	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0] <= item_d;
			rem_s[0] <= CNT_W'(sample_index);
			den_s[0] <= den;
			quo_s[0] <= '0;
			for (int k = 1; k <= F; k++) begin
				item_s[k] <= item_s[k-1];
				rem_s[k] <= rem_n[k];
				den_s[k] <= den_s[k-1];
				quo_s[k] <= {quo_s[k-1][F-2:0], qb_n[k]};
			end
		end
	end

	// Hand the finished request to the queue
	assign q_push = vld_s[F] && en;
	always_comb begin
		priority if (item_s[F].one) begin
			t_val = {1'b1, {F{1'b0}}};
		end else if (item_s[F].zero) begin
			t_val = '0;
		end else begin
			t_val = {1'b0, quo_s[F]};
		end
	end
	assign ax = item_s[F].ax;
	assign bx = item_s[F].bx;
	assign cx = item_s[F].cx;
	assign ay = item_s[F].ay;
	assign by = item_s[F].by;
	assign cy = item_s[F].cy;
	assign x0 = item_s[F].x0;
	assign y0 = item_s[F].y0;
	assign clip = item_s[F].clip;
endmodule
`default_nettype wire

// File: sv/cbpg_fifo.sv
// Short queue between the front and back parts.
`default_nettype none
module cbpg_fifo
	import cbpg_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  full,
	output logic                  empty
);
	logic [WIDTH-1:0] mem_q [0:QDEPTH-1];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;
	logic             do_push;
	logic             do_pop;

	assign full = count_q == (QAW+1)'(QDEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end

	// Store the request
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end
endmodule
`default_nettype wire

// File: sv/cbpg_axis.sv
// Horner evaluation pipeline for one coordinate axis.
`default_nettype none
module cbpg_axis #(
	parameter int COORD_BITS = 16,
	parameter int T_FRACTION_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [T_FRACTION_BITS:0]     t_val,
	input  wire logic signed [COORD_BITS+3:0] a,
	input  wire logic signed [COORD_BITS+3:0] b,
	input  wire logic signed [COORD_BITS+3:0] c,
	input  wire logic signed [COORD_BITS-1:0] p0,
	output logic signed [COORD_BITS-1:0]      point,
	output logic                              sat
);
	localparam int CW = COORD_BITS;
	localparam int F = T_FRACTION_BITS;
	localparam int KW = CW + 4;
	localparam int TW = F + 1;
	localparam int SW = CW + F + 6;
	localparam int HW = SW - F;
	localparam int PW = HW + TW + 1;
	localparam int LW = F + TW;
	localparam logic signed [HW-1:0] MAXC = HW'((2**(CW-1)) - 1);
	localparam logic signed [HW-1:0] MINC = -HW'(2**(CW-1));

	// Place an integer coefficient at the fraction point
	function automatic logic signed [SW-1:0] fix(input logic signed [KW-1:0] v);
		return {{(SW-KW-F){v[KW-1]}}, v, {F{1'b0}}};
	endfunction

	logic signed [SW-1:0] m_s1;
	logic signed [KW-1:0] b_s1, c_s1, c_s2, c_s3, p0_s1, p0_s2, p0_s3, p0_s4, p0_s5;
	logic [TW-1:0]        t_s1, t_s2, t_s3, t_s4;
	logic signed [SW-1:0] s_s2, s_s4, s_s6;
	logic signed [SW-1:0] hh_s3, hh_s5;
	logic [TW-1:0]        lt_s3, lt_s5;
	logic signed [CW-1:0] point_s7;
	logic                 sat_s7;

	logic signed [HW+TW:0] hh2_full, hh4_full;
	logic [F+TW-1:0]       lt2_full, lt4_full;
	logic signed [HW-1:0]  q6;
	logic signed [HW-1:0]  qt6;

	// Split each accumulator into whole and fraction parts for the t product
	assign hh2_full = PW'($signed(s_s2[SW-1:F])) * PW'($signed({1'b0, t_s2}));
	assign lt2_full = LW'(s_s2[F-1:0]) * LW'(t_s2);
	assign hh4_full = PW'($signed(s_s4[SW-1:F])) * PW'($signed({1'b0, t_s4}));
	assign lt4_full = LW'(s_s4[F-1:0]) * LW'(t_s4);

	// Truncate toward zero
	assign q6 = s_s6[SW-1:F];
	assign qt6 = q6 + HW'(s_s6[SW-1] && (|s_s6[F-1:0]));

	// Advance the evaluation stages
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= SW'(a) * SW'($signed({1'b0, t_val}));
			b_s1 <= b;
			c_s1 <= c;
			p0_s1 <= KW'(p0);
			t_s1 <= t_val;

			s_s2 <= m_s1 + fix(b_s1);
			c_s2 <= c_s1;
			p0_s2 <= p0_s1;
			t_s2 <= t_s1;

			hh_s3 <= hh2_full[SW-1:0];
			lt_s3 <= lt2_full[F+TW-1:F];
			c_s3 <= c_s2;
			p0_s3 <= p0_s2;
			t_s3 <= t_s2;

			s_s4 <= hh_s3 + $signed({{(SW-TW){1'b0}}, lt_s3}) + fix(c_s3);
			p0_s4 <= p0_s3;
			t_s4 <= t_s3;

			hh_s5 <= hh4_full[SW-1:0];
			lt_s5 <= lt4_full[F+TW-1:F];
			p0_s5 <= p0_s4;

			s_s6 <= hh_s5 + $signed({{(SW-TW){1'b0}}, lt_s5}) + fix(p0_s5);

			priority if (qt6 > MAXC) begin
				point_s7 <= MAXC[CW-1:0];
				sat_s7 <= 1'b1;
			end else if (qt6 < MINC) begin
				point_s7 <= MINC[CW-1:0];
				sat_s7 <= 1'b1;
			end else begin
				point_s7 <= qt6[CW-1:0];
				sat_s7 <= 1'b0;
			end
		end
	end

	assign point = point_s7;
	assign sat = sat_s7;
endmodule
`default_nettype wire

// File: sv/cbpg_back.sv
// Back part: pulls requests from the queue and evaluates both axes.
`default_nettype none
module cbpg_back #(
	parameter int COORD_BITS = 16,
	parameter int T_FRACTION_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_empty,
	output logic                              q_pop,
	input  wire logic [T_FRACTION_BITS:0]     t_val,
	input  wire logic signed [COORD_BITS+3:0] ax,
	input  wire logic signed [COORD_BITS+3:0] bx,
	input  wire logic signed [COORD_BITS+3:0] cx,
	input  wire logic signed [COORD_BITS+3:0] ay,
	input  wire logic signed [COORD_BITS+3:0] by,
	input  wire logic signed [COORD_BITS+3:0] cy,
	input  wire logic signed [COORD_BITS-1:0] x0,
	input  wire logic signed [COORD_BITS-1:0] y0,
	input  wire logic                         clip,
	output logic                              point_valid,
	input  wire logic                         point_stall,
	output logic signed [COORD_BITS-1:0]      point_x,
	output logic signed [COORD_BITS-1:0]      point_y,
	output logic                              clipped
);
	localparam int BL = 7;

	logic          en;
	logic [BL-1:0] vld_s;
	logic [BL-1:0] clp_s;
	logic          sat_x;
	logic          sat_y;

	// Hold every stage while the finished point waits
	assign en = !(vld_s[BL-1] && point_stall);
	assign q_pop = en && !q_empty;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[BL-2:0], !q_empty};
		end
	end

	// Carry the front clip flag alongside
	always_ff @(posedge clk) begin
		if (en) begin
			clp_s <= {clp_s[BL-2:0], clip};
		end
	end

	cbpg_axis #(
		.COORD_BITS(COORD_BITS),
		.T_FRACTION_BITS(T_FRACTION_BITS)
	) u_axis_x (
		.clk(clk),
		.en(en),
		.t_val(t_val),
		.a(ax),
		.b(bx),
		.c(cx),
		.p0(x0),
		.point(point_x),
		.sat(sat_x)
	);

	cbpg_axis #(
		.COORD_BITS(COORD_BITS),
		.T_FRACTION_BITS(T_FRACTION_BITS)
	) u_axis_y (
		.clk(clk),
		.en(en),
		.t_val(t_val),
		.a(ay),
		.b(by),
		.c(cy),
		.p0(y0),
		.point(point_y),
		.sat(sat_y)
	);

	assign point_valid = vld_s[BL-1];
	assign clipped = clp_s[BL-1] || sat_x || sat_y;
endmodule
`default_nettype wire

// File: sv/cubic_bezier_point_generator.sv
// Throughput: one point per cycle while point_stall is low; the front runs one divider bit per stage to form t,
// and the back evaluates both axes in a seven-stage Horner pipeline.
// A four-entry queue between them absorbs output stalls before the input stalls.
// Reset (arst_n low, asynchronous) clears all valid bits and queue pointers; no clearing pass.
`default_nettype none
module cubic_bezier_point_generator
	import cbpg_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int T_FRACTION_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         sample_valid,
	output logic                              sample_stall,
	input  wire logic signed [COORD_BITS-1:0] p0_x,
	input  wire logic signed [COORD_BITS-1:0] p0_y,
	input  wire logic signed [COORD_BITS-1:0] p1_x,
	input  wire logic signed [COORD_BITS-1:0] p1_y,
	input  wire logic signed [COORD_BITS-1:0] p2_x,
	input  wire logic signed [COORD_BITS-1:0] p2_y,
	input  wire logic signed [COORD_BITS-1:0] p3_x,
	input  wire logic signed [COORD_BITS-1:0] p3_y,
	input  wire logic [IDX_W-1:0]             sample_index,
	input  wire logic [CNT_W-1:0]             sample_count,
	output logic                              point_valid,
	input  wire logic                         point_stall,
	output logic signed [COORD_BITS-1:0]      point_x,
	output logic signed [COORD_BITS-1:0]      point_y,
	output logic                              clipped
);
	localparam int CW = COORD_BITS;
	localparam int KW = CW + 4;
	localparam int TW = T_FRACTION_BITS + 1;
	localparam int QW = 6 * KW + 2 * CW + TW + 1;

	logic                 q_full, q_empty, q_push, q_pop;
	logic [QW-1:0]        q_wdata, q_rdata;
	logic [TW-1:0]        f_t, b_t;
	logic signed [KW-1:0] f_ax, f_bx, f_cx, f_ay, f_by, f_cy;
	logic signed [KW-1:0] b_ax, b_bx, b_cx, b_ay, b_by, b_cy;
	logic signed [CW-1:0] f_x0, f_y0, b_x0, b_y0;
	logic                 f_clip, b_clip;

	cbpg_front #(
		.COORD_BITS(COORD_BITS),
		.T_FRACTION_BITS(T_FRACTION_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.p0_x(p0_x),
		.p0_y(p0_y),
		.p1_x(p1_x),
		.p1_y(p1_y),
		.p2_x(p2_x),
		.p2_y(p2_y),
		.p3_x(p3_x),
		.p3_y(p3_y),
		.sample_index(sample_index),
		.sample_count(sample_count),
		.q_full(q_full),
		.q_push(q_push),
		.t_val(f_t),
		.ax(f_ax),
		.bx(f_bx),
		.cx(f_cx),
		.ay(f_ay),
		.by(f_by),
		.cy(f_cy),
		.x0(f_x0),
		.y0(f_y0),
		.clip(f_clip)
	);

	// Pack the request for the queue
	assign q_wdata = {f_ax, f_bx, f_cx, f_ay, f_by, f_cy, f_x0, f_y0, f_t, f_clip};

	cbpg_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.pop(q_pop),
		.rdata(q_rdata),
		.full(q_full),
		.empty(q_empty)
	);

	// Unpack the request at the queue head
	assign {b_ax, b_bx, b_cx, b_ay, b_by, b_cy, b_x0, b_y0, b_t, b_clip} = q_rdata;

	cbpg_back #(
		.COORD_BITS(COORD_BITS),
		.T_FRACTION_BITS(T_FRACTION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.t_val(b_t),
		.ax(b_ax),
		.bx(b_bx),
		.cx(b_cx),
		.ay(b_ay),
		.by(b_by),
		.cy(b_cy),
		.x0(b_x0),
		.y0(b_y0),
		.clip(b_clip),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point_x(point_x),
		.point_y(point_y),
		.clipped(clipped)
	);
endmodule
`default_nettype wire

// File: sv/cbpg_checker.sv
// Port-level checker for the cubic Bezier point generator, bound to the top level.
`default_nettype none
`include "cubic_bezier_point_generator_assert.svh"
module cbpg_checker #(
	parameter int COORD_BITS = 16
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  sample_stall,
	input wire logic                  point_valid,
	input wire logic                  point_stall,
	input wire logic [COORD_BITS-1:0] point_x,
	input wire logic [COORD_BITS-1:0] point_y,
	input wire logic                  clipped
);
	// A stalled point holds
	`CBPG_ASSERT_NXT(a_point_hold, clk, arst_n, point_valid && point_stall, point_valid && $stable(point_x) && $stable(point_y) && $stable(clipped))

	// The input stalls only after the output has been held back
	`CBPG_ASSERT_IMP(a_stall_cause, clk, arst_n, $rose(sample_stall), $past(point_valid && point_stall))

	// Once the output drains, the input stall drops the next cycle
	`CBPG_ASSERT_NXT(a_stall_drain, clk, arst_n, sample_stall && !(point_valid && point_stall), !sample_stall)

	// Come out of reset empty and ready
	`CBPG_ASSERT_IMP(a_reset_idle, clk, arst_n, $past(!arst_n), !point_valid && !sample_stall)
endmodule

bind cubic_bezier_point_generator cbpg_checker #(.COORD_BITS(COORD_BITS)) u_cbpg_checker (.*);
`default_nettype wire
